// File: rtl/voice_message_fragmenter_crc32_assert.svh
// Assertion macros used by the checker file.
`ifndef VOICE_MESSAGE_FRAGMENTER_CRC32_ASSERT_SVH
`define VOICE_MESSAGE_FRAGMENTER_CRC32_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define VMFC_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define VMFC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/vmfc_pkg.sv
package vmfc_pkg;

   localparam int MAX_FRAGMENTS      = 64;
   localparam int FRAGMENT_DATA_BITS = 490;
   localparam int FRAGMENT_BYTES     = 66;

   localparam int HEADER_BITS = 6;
   localparam int FRAG_BITS   = FRAGMENT_BYTES * 8;
   localparam int TOTAL_BITS  = FRAG_BITS + 32;
   localparam int DATA_END    = HEADER_BITS + FRAGMENT_DATA_BITS;
   // bytes in the word that carries the end of the CRC
   localparam int TAIL_BYTES  = ((TOTAL_BITS - 1) % 64) / 8 + 1;

   localparam int POS_W = $clog2(TOTAL_BITS + 1);
   localparam int IDX_W = (MAX_FRAGMENTS > 1) ? $clog2(MAX_FRAGMENTS) : 1;

   localparam int GROUP_BYTES = 9;

   // 0x04c11db7 in reflected form
   localparam logic [31:0] CRC_POLY_REFLECTED = 32'hEDB88320;
   localparam logic [31:0] CRC_INIT           = 32'hFFFFFFFF;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [7:0] data;
      logic       msg_end;
      logic [8:0] groups;
   } q_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   typedef enum logic [0:0] {F_PASS, F_PAD} front_state_type;

   typedef enum logic [1:0] {B_DATA, B_ZERO, B_CRC, B_REST} back_state_type;

   function automatic logic [31:0] crc_byte_update(input logic [31:0] crc,
                                                   input logic [7:0]  b);
      logic [31:0] c;
      c = crc ^ {24'h000000, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY_REFLECTED) : (c >> 1);
      end
      return c;
   endfunction

endpackage

// File: rtl/voice_message_fragmenter_crc32.sv
// channel  direction  handshake             payload
// req      in         req_valid/req_stall   msg_byte, last_byte
// rsp      out        rsp_valid/rsp_stall   frag_word, valid_bytes, frag_number, flags, counts
//
// One message byte per cycle while it stays inside a fragment; the back end
// inserts up to eight bits and folds one byte into the CRC each cycle.
// Closing a fragment zero-fills it a byte at a time, appends the four CRC
// bytes and then inserts the bits carried into the next fragment.
// The message is padded with zero bytes to a multiple of nine bytes at one
// byte per cycle while the queue has room, input stalled meanwhile. Reset
// is synchronous; a full queue stalls the input (a stalled result word fills it).
module voice_message_fragmenter_crc32 (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_msg_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_frag_word,
   output logic [3:0]  rsp_valid_bytes,
   output logic [5:0]  rsp_frag_number,
   output logic        rsp_last_of_fragment,
   output logic        rsp_last_of_message,
   output logic [8:0]  rsp_group_count,
   output logic [6:0]  rsp_fragment_count
);
   import vmfc_pkg::*;

   q_status_type q_status;
   q_entry_type  q_wdata;
   q_entry_type  q_rdata;
   logic         q_push;
   logic         q_pop;

   vmfc_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_msg_byte  (req_msg_byte),
      .req_last_byte (req_last_byte),
      .q_status      (q_status),
      .q_push        (q_push),
      .q_wdata       (q_wdata)
   );

   vmfc_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (q_push),
      .wdata  (q_wdata),
      .pop    (q_pop),
      .rdata  (q_rdata),
      .status (q_status)
   );

   vmfc_back u_back (
      .clock                (clock),
      .reset                (reset),
      .q_status             (q_status),
      .q_rdata              (q_rdata),
      .q_pop                (q_pop),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_frag_word        (rsp_frag_word),
      .rsp_valid_bytes      (rsp_valid_bytes),
      .rsp_frag_number      (rsp_frag_number),
      .rsp_last_of_fragment (rsp_last_of_fragment),
      .rsp_last_of_message  (rsp_last_of_message),
      .rsp_group_count      (rsp_group_count),
      .rsp_fragment_count   (rsp_fragment_count)
   );

endmodule

// File: rtl/vmfc_front.sv
module vmfc_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_msg_byte,
   input  logic                  req_last_byte,
   input  vmfc_pkg::q_status_type q_status,
   output logic                  q_push,
   output vmfc_pkg::q_entry_type q_wdata
);
   import vmfc_pkg::*;

   front_state_type state_ff, state_in;
   logic [3:0] mod9_ff, mod9_in;
   logic [8:0] grp_ff, grp_in;

   logic       take;
   logic       pad_go;
   logic       wrap;
   logic [8:0] grp_inc;
   logic       msg_end;

   assign wrap    = (mod9_ff == 4'(GROUP_BYTES - 1));
   assign grp_inc = (wrap && (grp_ff != '1)) ? grp_ff + 9'd1 : grp_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         F_PASS: begin
            if (take && req_last_byte && !wrap) state_in = F_PAD;
         end
         F_PAD: begin
            if (pad_go && wrap) state_in = F_PASS;
         end
         default: state_in = F_PASS;
      endcase
   end

   always_comb begin
      req_stall = q_status.full || (state_ff == F_PAD);
      take      = req_valid && !req_stall;
      pad_go    = (state_ff == F_PAD) && !q_status.full;
      q_push    = take || pad_go;
      msg_end   = ((take && req_last_byte) || pad_go) && wrap;

      q_wdata.data    = take ? req_msg_byte : 8'h00;
      q_wdata.msg_end = msg_end;
      q_wdata.groups  = grp_inc;

      mod9_in = mod9_ff;
      grp_in  = grp_ff;
      if (q_push) begin
         mod9_in = wrap ? 4'd0 : mod9_ff + 4'd1;
         grp_in  = msg_end ? 9'd0 : grp_inc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_PASS;
         mod9_ff  <= 4'd0;
         grp_ff   <= 9'd0;
      end else begin
         state_ff <= state_in;
         mod9_ff  <= mod9_in;
         grp_ff   <= grp_in;
      end
   end

endmodule

// File: rtl/vmfc_queue.sv
module vmfc_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  vmfc_pkg::q_entry_type  wdata,
   input  logic                   pop,
   output vmfc_pkg::q_entry_type  rdata,
   output vmfc_pkg::q_status_type status
);
   import vmfc_pkg::*;

   q_entry_type         slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wptr_ff, wptr_in;
   logic [QPTR_W-1:0]   rptr_ff, rptr_in;
   logic [QCNT_W-1:0]   cnt_ff, cnt_in;

   always_comb begin
      status.full  = (cnt_ff == QCNT_W'(QUEUE_DEPTH));
      status.empty = (cnt_ff == '0);
      rdata        = slot_ff[rptr_ff];

      wptr_in = push ? wptr_ff + QPTR_W'(1) : wptr_ff;
      rptr_in = pop  ? rptr_ff + QPTR_W'(1) : rptr_ff;
      cnt_in  = cnt_ff;
      if (push && !pop) cnt_in = cnt_ff + QCNT_W'(1);
      else if (pop && !push) cnt_in = cnt_ff - QCNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wptr_ff] <= wdata;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

endmodule

// File: rtl/vmfc_back.sv
module vmfc_back (
   input  logic                   clock,
   input  logic                   reset,
   input  vmfc_pkg::q_status_type q_status,
   input  vmfc_pkg::q_entry_type  q_rdata,
   output logic                   q_pop,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [63:0]            rsp_frag_word,
   output logic [3:0]             rsp_valid_bytes,
   output logic [5:0]             rsp_frag_number,
   output logic                   rsp_last_of_fragment,
   output logic                   rsp_last_of_message,
   output logic [8:0]             rsp_group_count,
   output logic [6:0]             rsp_fragment_count
);
   import vmfc_pkg::*;

   back_state_type   state_ff, state_in;
   logic [63:0]      word_ff, word_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [31:0]      crc_ff, crc_in;
   logic [7:0]       rest_ff, rest_in;
   logic [3:0]       rest_k_ff, rest_k_in;
   logic             rest_pend_ff, rest_pend_in;
   logic             end_pend_ff, end_pend_in;
   logic [8:0]       grp_ff, grp_in;
   logic [1:0]       ccnt_ff, ccnt_in;

   logic             out_valid_ff;
   logic [63:0]      out_word_ff;
   logic [3:0]       out_bytes_ff;
   logic [5:0]       out_num_ff;
   logic             out_lof_ff;
   logic             out_lom_ff;
   logic [8:0]       out_grp_ff;
   logic [6:0]       out_cnt_ff;

   logic             adv;
   logic             take;
   logic             step;
   logic [7:0]       push_bits;
   logic [3:0]       push_k;
   logic             frag_done;
   logic             final_close;
   logic             last_frag;
   logic [POS_W-1:0] room;
   logic [POS_W-1:0] to_frag_end;
   logic [3:0]       to_byte_end;
   logic [31:0]      crc_out;

   // bit inserter
   logic [5:0]       off;
   logic [7:0]       masked;
   logic [127:0]     window;
   logic [POS_W-1:0] pos_new;
   logic [6:0]       rel;
   logic             crossed;
   logic [3:0]       byte_sel;
   logic [7:0]       done_byte;
   logic             frag_end;
   logic             emit;
   logic [63:0]      word_after;
   logic [IDX_W-1:0] idx_next;

   assign adv       = !out_valid_ff || !rsp_stall;
   assign take      = (state_ff == B_DATA) && adv && !q_status.empty;
   assign step      = adv && ((state_ff != B_DATA) || take);
   assign q_pop     = take;
   assign last_frag = (idx_ff == IDX_W'(MAX_FRAGMENTS - 1));
   assign crc_out   = ~crc_ff;
   assign room      = POS_W'(DATA_END) - pos_ff;
   assign to_frag_end = POS_W'(FRAG_BITS) - pos_ff;
   assign to_byte_end = 4'd8 - {1'b0, pos_ff[2:0]};

   always_comb begin
      off        = pos_ff[5:0];
      masked     = push_bits & ~(8'hFF >> push_k);
      window     = {word_ff, 64'h0} | ({masked, 120'h0} >> off);
      pos_new    = pos_ff + POS_W'(push_k);
      rel        = {1'b0, off} + 7'(push_k);
      crossed    = (pos_new[POS_W-1:3] != pos_ff[POS_W-1:3]);
      byte_sel   = rel[6:3] - 4'd1;
      done_byte  = 8'h00;
      for (int b = 0; b < 9; b++) begin
         if (byte_sel == 4'(b)) done_byte = window[127 - 8 * b -: 8];
      end
      frag_end   = (pos_new == POS_W'(TOTAL_BITS));
      emit       = rel[6] || frag_end;
      word_after = rel[6] ? window[63:0] : window[127:64];
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_DATA: begin
            if (take && (rest_pend_in || q_rdata.msg_end)) state_in = B_ZERO;
         end
         B_ZERO: begin
            if (pos_new == POS_W'(FRAG_BITS)) state_in = B_CRC;
         end
         B_CRC: begin
            if (frag_done) state_in = rest_pend_ff ? B_REST : B_DATA;
         end
         B_REST: begin
            state_in = end_pend_ff ? B_ZERO : B_DATA;
         end
         default: state_in = B_DATA;
      endcase
   end

   always_comb begin
      push_bits    = 8'h00;
      push_k       = 4'd0;
      rest_in      = rest_ff;
      rest_k_in    = rest_k_ff;
      rest_pend_in = rest_pend_ff;
      end_pend_in  = end_pend_ff;
      grp_in       = grp_ff;
      ccnt_in      = ccnt_ff;
      frag_done    = 1'b0;
      final_close  = end_pend_ff && !rest_pend_ff;

      unique case (state_ff)
         B_DATA: begin
            push_bits = q_rdata.data;
            if (take) begin
               end_pend_in = q_rdata.msg_end;
               grp_in      = q_rdata.groups;
            end
            if (pos_ff >= POS_W'(DATA_END)) begin
               // fragment is full: the whole byte opens the next one, unless this is the last fragment
               if (!last_frag) begin
                  rest_in      = q_rdata.data;
                  rest_k_in    = 4'd8;
                  rest_pend_in = take;
               end
            end else if (room >= POS_W'(8)) begin
               push_k = 4'd8;
            end else begin
               push_k = room[3:0];
               if (!last_frag) begin
                  rest_in      = q_rdata.data << room[3:0];
                  rest_k_in    = 4'd8 - room[3:0];
                  rest_pend_in = take;
               end
            end
            ccnt_in = 2'd0;
         end
         B_ZERO: begin
            push_k  = (to_frag_end < POS_W'(to_byte_end)) ? to_frag_end[3:0] : to_byte_end;
            ccnt_in = 2'd0;
         end
         B_CRC: begin
            unique case (ccnt_ff)
               2'd0: push_bits = crc_out[31:24];
               2'd1: push_bits = crc_out[23:16];
               2'd2: push_bits = crc_out[15:8];
               2'd3: push_bits = crc_out[7:0];
               default: push_bits = 8'h00;
            endcase
            push_k    = 4'd8;
            ccnt_in   = ccnt_ff + 2'd1;
            frag_done = frag_end;
            if (frag_done && final_close) end_pend_in = 1'b0;
         end
         B_REST: begin
            push_bits    = rest_ff;
            push_k       = rest_k_ff;
            rest_pend_in = 1'b0;
         end
         default: begin
            push_k = 4'd0;
         end
      endcase

      idx_next = final_close ? '0 : idx_ff + IDX_W'(1);

      word_in = word_ff;
      pos_in  = pos_ff;
      idx_in  = idx_ff;
      crc_in  = crc_ff;
      if (frag_done) begin
         word_in = {6'(idx_next), 58'h0};
         pos_in  = POS_W'(HEADER_BITS);
         idx_in  = idx_next;
         crc_in  = CRC_INIT;
      end else begin
         word_in = word_after;
         pos_in  = pos_new;
         if (crossed && (pos_new <= POS_W'(FRAG_BITS))) begin
            crc_in = crc_byte_update(crc_ff, done_byte);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_DATA;
         word_ff      <= 64'h0;
         pos_ff       <= POS_W'(HEADER_BITS);
         idx_ff       <= '0;
         crc_ff       <= CRC_INIT;
         rest_pend_ff <= 1'b0;
         end_pend_ff  <= 1'b0;
         ccnt_ff      <= 2'd0;
         out_valid_ff <= 1'b0;
      end else begin
         if (step) begin
            state_ff     <= state_in;
            word_ff      <= word_in;
            pos_ff       <= pos_in;
            idx_ff       <= idx_in;
            crc_ff       <= crc_in;
            rest_pend_ff <= rest_pend_in;
            end_pend_ff  <= end_pend_in;
            ccnt_ff      <= ccnt_in;
         end
         if (adv) out_valid_ff <= step && emit;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rest_ff   <= rest_in;
         rest_k_ff <= rest_k_in;
         grp_ff    <= grp_in;
      end
      if (step && emit) begin
         out_word_ff  <= window[127:64];
         out_bytes_ff <= frag_end ? 4'(TAIL_BYTES) : 4'd8;
         out_num_ff   <= 6'(idx_ff);
         out_lof_ff   <= frag_end;
         out_lom_ff   <= frag_end && final_close;
         out_grp_ff   <= (frag_end && final_close) ? grp_ff : 9'd0;
         out_cnt_ff   <= (frag_end && final_close) ? 7'(idx_ff) + 7'd1 : 7'd0;
      end
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_frag_word        = out_word_ff;
   assign rsp_valid_bytes      = out_bytes_ff;
   assign rsp_frag_number      = out_num_ff;
   assign rsp_last_of_fragment = out_lof_ff;
   assign rsp_last_of_message  = out_lom_ff;
   assign rsp_group_count      = out_grp_ff;
   assign rsp_fragment_count   = out_cnt_ff;

endmodule

// File: rtl/vmfc_checker.sv
`include "voice_message_fragmenter_crc32_assert.svh"

module vmfc_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [63:0] rsp_frag_word,
   input logic [3:0]  rsp_valid_bytes,
   input logic [5:0]  rsp_frag_number,
   input logic        rsp_last_of_fragment,
   input logic        rsp_last_of_message,
   input logic [8:0]  rsp_group_count,
   input logic [6:0]  rsp_fragment_count
);

   // stalled transaction is held
   `VMFC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_frag_word) && $stable(rsp_last_of_fragment), "rsp transaction changed under stall")

   `VMFC_ASSERT_IMPLY(a_msg_ends_frag, clock, reset, rsp_valid && rsp_last_of_message, rsp_last_of_fragment, "message end without fragment end")

   `VMFC_ASSERT_IMPLY(a_full_word, clock, reset, rsp_valid && !rsp_last_of_fragment, rsp_valid_bytes == 4'd8, "short word inside fragment")

   `VMFC_ASSERT_IMPLY(a_counts_zero, clock, reset, rsp_valid && !rsp_last_of_message, (rsp_group_count == 9'd0) && (rsp_fragment_count == 7'd0), "counts outside message end")

   `VMFC_ASSERT_IMPLY(a_frag_count, clock, reset, rsp_valid && rsp_last_of_message, rsp_fragment_count == {1'b0, rsp_frag_number} + 7'd1, "fragment count mismatch")

endmodule

bind voice_message_fragmenter_crc32 vmfc_checker u_vmfc_checker (
   .clock                (clock),
   .reset                (reset),
   .rsp_valid            (rsp_valid),
   .rsp_stall            (rsp_stall),
   .rsp_frag_word        (rsp_frag_word),
   .rsp_valid_bytes      (rsp_valid_bytes),
   .rsp_frag_number      (rsp_frag_number),
   .rsp_last_of_fragment (rsp_last_of_fragment),
   .rsp_last_of_message  (rsp_last_of_message),
   .rsp_group_count      (rsp_group_count),
   .rsp_fragment_count   (rsp_fragment_count)
);
